### sv/priority_interrupt_dispatch_core_defines.svh
// Assertion macros shared by the interrupt dispatch RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef PRIORITY_INTERRUPT_DISPATCH_CORE_DEFINES_SVH
`define PRIORITY_INTERRUPT_DISPATCH_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PID_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pid assertion failed");

// Check a property on every clock edge, reset included.
`define PID_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("pid assertion failed");

`endif

### sv/pid_pkg.sv
// Types and constants for the priority interrupt dispatch block.
// No dependencies; used by pid_resolve and priority_interrupt_dispatch_core.
package pid_pkg;

  localparam int unsigned NumSources = 5;
  localparam int unsigned SrcIdxW    = $clog2(NumSources);

  localparam logic [NumSources-1:0] StatSourceBit = 5'b0_0010;
  localparam logic [15:0]           VectorBase    = 16'h0040;
  localparam logic [15:0]           StackStep     = 16'd2;
  localparam logic [4:0]            DispatchCycles = 5'd20;

  // Display status byte layout
  localparam logic [1:0] Mode0 = 2'd0;
  localparam logic [1:0] Mode1 = 2'd1;
  localparam logic [1:0] Mode2 = 2'd2;
  localparam int unsigned StatSelMode0 = 3;
  localparam int unsigned StatSelMode1 = 4;
  localparam int unsigned StatSelMode2 = 5;
  localparam int unsigned StatSelMatch = 6;

  typedef struct packed {
    logic [NumSources-1:0] enable_mask;
    logic [NumSources-1:0] request_flags;
    logic                  master_enable;
    logic [7:0]            status_byte;
    logic [7:0]            line_compare;
    logic [7:0]            current_line;
    logic [15:0]           program_counter;
    logic [15:0]           stack_pointer;
  } pid_req_t;

  typedef struct packed {
    logic                  wake;
    logic                  dispatch;
    logic [15:0]           vector_address;
    logic [NumSources-1:0] next_flags;
    logic                  next_master_enable;
    logic [15:0]           next_stack_pointer;
    logic [7:0]            push_high_byte;
    logic [7:0]            push_low_byte;
    logic [4:0]            added_cycles;
  } pid_res_t;

endpackage

### sv/pid_resolve.sv
// Combinational interrupt check: status request, priority pick and dispatch results.
// Depends on pid_pkg.
module pid_resolve
  import pid_pkg::*;
(
  input  pid_req_t req_i,
  output pid_res_t res_o
);

  logic                  stat_hit;
  logic [NumSources-1:0] flags;
  logic [NumSources-1:0] pending;
  logic                  found;
  logic [SrcIdxW-1:0]    win_idx;
  logic [NumSources-1:0] win_bit;
  logic                  take;

  always_comb begin
    stat_hit = (req_i.status_byte[StatSelMatch] && (req_i.line_compare == req_i.current_line))
            || (req_i.status_byte[StatSelMode2] && (req_i.status_byte[1:0] == Mode2))
            || (req_i.status_byte[StatSelMode1] && (req_i.status_byte[1:0] == Mode1))
            || (req_i.status_byte[StatSelMode0] && (req_i.status_byte[1:0] == Mode0));
  end

  assign flags   = ((req_i.enable_mask & StatSourceBit) != '0) && stat_hit
                 ? (req_i.request_flags | StatSourceBit) : req_i.request_flags;
  assign pending = req_i.enable_mask & flags;

  // Lowest index wins: scan from the top so the last hit is the lowest
  always_comb begin
    found   = 1'b0;
    win_idx = '0;
    win_bit = '0;
    for (int i = NumSources - 1; i >= 0; i--) begin
      if (pending[i]) begin
        found   = 1'b1;
        win_idx = SrcIdxW'(i);
        win_bit = NumSources'(1) << i;
      end
    end
  end

  assign take = found && req_i.master_enable;

  always_comb begin
    res_o.wake               = found;
    res_o.dispatch           = take;
    res_o.vector_address     = req_i.program_counter;
    res_o.next_flags         = flags;
    res_o.next_master_enable = req_i.master_enable;
    res_o.next_stack_pointer = req_i.stack_pointer;
    res_o.push_high_byte     = '0;
    res_o.push_low_byte      = '0;
    res_o.added_cycles       = '0;
    if (take) begin
      res_o.vector_address     = VectorBase + {{(13 - SrcIdxW){1'b0}}, win_idx, 3'b000};
      res_o.next_flags         = flags & ~win_bit;
      res_o.next_master_enable = 1'b0;
      res_o.next_stack_pointer = req_i.stack_pointer - StackStep;
      res_o.push_high_byte     = req_i.program_counter[15:8];
      res_o.push_low_byte      = req_i.program_counter[7:0];
      res_o.added_cycles       = DispatchCycles;
    end
  end

endmodule

### sv/priority_interrupt_dispatch_core.sv
// Channel  | Direction | Handshake               | Payload
// request  | in        | in_valid_i / in_ready_o | interrupt and CPU snapshot
// result   | out       | out_valid_o/out_ready_i | dispatch decision and push data
//
// One request per cycle while the result is not stalled; input register, then result register.
// Only pid_resolve is between them: status check, priority pick, 16-bit add and subtract.
// Reset clears both valid flags; payload registers are not reset.
// A stalled result holds both stages; the input register drains into the
// result register as soon as it is free, so a new request is taken while a
// result waits. Depends on pid_pkg, pid_resolve and the defines header.
`include "priority_interrupt_dispatch_core_defines.svh"

module priority_interrupt_dispatch_core
  import pid_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [NumSources-1:0] enable_mask_i,
  input  logic [NumSources-1:0] request_flags_i,
  input  logic                  master_enable_i,
  input  logic [7:0]            status_byte_i,
  input  logic [7:0]            line_compare_i,
  input  logic [7:0]            current_line_i,
  input  logic [15:0]           program_counter_i,
  input  logic [15:0]           stack_pointer_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  wake_o,
  output logic                  dispatch_o,
  output logic [15:0]           vector_address_o,
  output logic [NumSources-1:0] next_flags_o,
  output logic                  next_master_enable_o,
  output logic [15:0]           next_stack_pointer_o,
  output logic [7:0]            push_high_byte_o,
  output logic [7:0]            push_low_byte_o,
  output logic [4:0]            added_cycles_o
);

  logic     s1_valid_q, s1_valid_d;
  logic     out_valid_q, out_valid_d;
  pid_req_t s1_req_q;
  pid_res_t res_d, res_q;
  logic     advance;
  logic     in_take;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = advance ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_req_q.enable_mask     <= enable_mask_i;
      s1_req_q.request_flags   <= request_flags_i;
      s1_req_q.master_enable   <= master_enable_i;
      s1_req_q.status_byte     <= status_byte_i;
      s1_req_q.line_compare    <= line_compare_i;
      s1_req_q.current_line    <= current_line_i;
      s1_req_q.program_counter <= program_counter_i;
      s1_req_q.stack_pointer   <= stack_pointer_i;
    end
    if (advance && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  pid_resolve u_resolve (
    .req_i (s1_req_q),
    .res_o (res_d)
  );

  assign out_valid_o          = out_valid_q;
  assign wake_o               = res_q.wake;
  assign dispatch_o           = res_q.dispatch;
  assign vector_address_o     = res_q.vector_address;
  assign next_flags_o         = res_q.next_flags;
  assign next_master_enable_o = res_q.next_master_enable;
  assign next_stack_pointer_o = res_q.next_stack_pointer;
  assign push_high_byte_o     = res_q.push_high_byte;
  assign push_low_byte_o      = res_q.push_low_byte;
  assign added_cycles_o       = res_q.added_cycles;

  `PID_ASSERT(a_take_fills_s1, in_valid_i && in_ready_o |=> s1_valid_q)
  `PID_ASSERT(a_free_out_ready, !out_valid_o |-> in_ready_o)
  `PID_ASSERT(a_dispatch_wakes,
              out_valid_o && dispatch_o |-> wake_o && !next_master_enable_o &&
              (added_cycles_o == DispatchCycles))
  `PID_ASSERT(a_idle_no_push,
              out_valid_o && !dispatch_o |-> (push_high_byte_o == '0) &&
              (push_low_byte_o == '0) && (added_cycles_o == '0))
  `PID_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o || rst_ni)

endmodule

### dv/pid_dispatch_checker.sv
// Checker for priority_interrupt_dispatch_core: watches both channels, predicts each
// result from the accepted request and compares it field by field.
// Depends on pid_pkg for the request and result layouts.
`timescale 1ns / 100ps

module pid_dispatch_checker
  import pid_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  pid_req_t req_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  pid_res_t res_i,
  output int       fail_count_o,
  output int       outstanding_o,
  output int       dispatch_count_o
);

  localparam logic [15:0] VectorStride = 16'h0008;

  pid_res_t expected_results[$];

  function automatic logic status_hit(input pid_req_t r);
    logic [1:0] mode;
    mode = r.status_byte[1:0];
    return (r.status_byte[StatSelMatch] && r.line_compare == r.current_line) ||
           (r.status_byte[StatSelMode2] && mode == Mode2) ||
           (r.status_byte[StatSelMode1] && mode == Mode1) ||
           (r.status_byte[StatSelMode0] && mode == Mode0);
  endfunction

  // Raise the status request, pick the lowest pending enabled source, take it if allowed.
  function automatic pid_res_t resolve_interrupt(input pid_req_t r);
    pid_res_t              res;
    logic [NumSources-1:0] flags;
    logic [NumSources-1:0] pending;
    logic                  found;
    flags = r.request_flags;
    if ((r.enable_mask & StatSourceBit) != '0 && status_hit(r)) flags = flags | StatSourceBit;
    res.wake               = 1'b0;
    res.dispatch           = 1'b0;
    res.vector_address     = r.program_counter;
    res.next_master_enable = r.master_enable;
    res.next_stack_pointer = r.stack_pointer;
    res.push_high_byte     = 8'h00;
    res.push_low_byte      = 8'h00;
    res.added_cycles       = 5'd0;
    pending = r.enable_mask & flags;
    found   = 1'b0;
    for (int i = 0; i < NumSources; i++) begin
      if (!found && pending[i]) begin
        found    = 1'b1;
        res.wake = 1'b1;
        if (r.master_enable) begin
          res.dispatch           = 1'b1;
          res.next_master_enable = 1'b0;
          flags[i]               = 1'b0;
          res.next_stack_pointer = r.stack_pointer - StackStep;
          res.push_high_byte     = r.program_counter[15:8];
          res.push_low_byte      = r.program_counter[7:0];
          res.vector_address     = VectorBase + 16'(i * VectorStride);
          res.added_cycles       = DispatchCycles;
        end
      end
    end
    res.next_flags = flags;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    fail_count_o++;
  endtask

  task automatic compare_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin
    pid_res_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        want = resolve_interrupt(req_i);
        if (want.dispatch) dispatch_count_o++;
        expected_results.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding", 16'h0, 16'h0);
        end else begin
          want = expected_results.pop_front();
          compare_field("wake", 16'(res_i.wake), 16'(want.wake));
          compare_field("dispatch", 16'(res_i.dispatch), 16'(want.dispatch));
          compare_field("vector_address", res_i.vector_address, want.vector_address);
          compare_field("next_flags", 16'(res_i.next_flags), 16'(want.next_flags));
          compare_field("next_master_enable", 16'(res_i.next_master_enable),
                        16'(want.next_master_enable));
          compare_field("next_stack_pointer", res_i.next_stack_pointer,
                        want.next_stack_pointer);
          compare_field("push_high_byte", 16'(res_i.push_high_byte),
                        16'(want.push_high_byte));
          compare_field("push_low_byte", 16'(res_i.push_low_byte),
                        16'(want.push_low_byte));
          compare_field("added_cycles", 16'(res_i.added_cycles),
                        16'(want.added_cycles));
        end
      end
      outstanding_o = expected_results.size();
    end
  end

endmodule

### dv/priority_interrupt_dispatch_core_tb.sv
// Top of the testbench for priority_interrupt_dispatch_core: clock, reset, request
// stimulus, output back-pressure and the verdict. Depends on pid_pkg and
// pid_dispatch_checker.
`timescale 1ns / 100ps

module priority_interrupt_dispatch_core_tb
  import pid_pkg::*;
();

  localparam int CycleLimit   = 200000;
  localparam int DrainCycles  = 8;
  localparam int HoldCycles   = 300;
  localparam int PhaseItems   = 455;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  logic     out_valid_o;
  logic     out_ready_i;
  pid_req_t drive_req;
  pid_res_t observed;

  logic                  wake_o, dispatch_o, next_master_enable_o;
  logic [15:0]           vector_address_o, next_stack_pointer_o;
  logic [NumSources-1:0] next_flags_o;
  logic [7:0]            push_high_byte_o, push_low_byte_o;
  logic [4:0]            added_cycles_o;

  int   send_idle_pct;
  int   recv_idle_pct;
  int   items_sent;
  int   cycle_count;
  int   fail_count;
  int   outstanding;
  int   dispatch_count;
  logic req_taken;
  logic hold_active;
  event start_hold;

  priority_interrupt_dispatch_core dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .enable_mask_i        (drive_req.enable_mask),
    .request_flags_i      (drive_req.request_flags),
    .master_enable_i      (drive_req.master_enable),
    .status_byte_i        (drive_req.status_byte),
    .line_compare_i       (drive_req.line_compare),
    .current_line_i       (drive_req.current_line),
    .program_counter_i    (drive_req.program_counter),
    .stack_pointer_i      (drive_req.stack_pointer),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .wake_o               (wake_o),
    .dispatch_o           (dispatch_o),
    .vector_address_o     (vector_address_o),
    .next_flags_o         (next_flags_o),
    .next_master_enable_o (next_master_enable_o),
    .next_stack_pointer_o (next_stack_pointer_o),
    .push_high_byte_o     (push_high_byte_o),
    .push_low_byte_o      (push_low_byte_o),
    .added_cycles_o       (added_cycles_o)
  );

  assign observed = {wake_o, dispatch_o, vector_address_o, next_flags_o,
                     next_master_enable_o, next_stack_pointer_o, push_high_byte_o,
                     push_low_byte_o, added_cycles_o};

  pid_dispatch_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .req_i            (drive_req),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .res_i            (observed),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding),
    .dispatch_count_o (dispatch_count)
  );

  always #1 clk_i = ~clk_i;

  // Record the handshake at the edge; the sender reads it at the following falling edge.
  always @(posedge clk_i) req_taken <= in_valid_i && in_ready_o;

  always @(negedge clk_i) begin
    if (hold_active) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    hold_active = 1'b0;
    forever begin
      @(start_hold);
      hold_active = 1'b1;
      for (int n = 0; n < HoldCycles; n++) @(negedge clk_i);
      hold_active = 1'b0;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic pid_req_t make_snapshot(
      input logic [4:0] ie, input logic [4:0] flg, input logic me, input logic [7:0] stat,
      input logic [7:0] lyc, input logic [7:0] ly, input logic [15:0] pc,
      input logic [15:0] sp);
    pid_req_t r;
    r.enable_mask     = ie;
    r.request_flags   = flg;
    r.master_enable   = me;
    r.status_byte     = stat;
    r.line_compare    = lyc;
    r.current_line    = ly;
    r.program_counter = pc;
    r.stack_pointer   = sp;
    return r;
  endfunction

  // Mostly enabled and pending, with line matches and stack wrap made common.
  function automatic pid_req_t random_snapshot();
    pid_req_t r;
    r.enable_mask     = 5'($urandom_range(31));
    r.request_flags   = ($urandom_range(3) == 0) ? 5'h00 : 5'($urandom_range(31));
    r.master_enable   = ($urandom_range(3) != 0);
    r.status_byte     = 8'($urandom_range(255));
    r.current_line    = 8'($urandom_range(255));
    r.line_compare    = $urandom_range(1) ? r.current_line : 8'($urandom_range(255));
    r.program_counter = 16'($urandom_range(65535));
    r.stack_pointer   = ($urandom_range(15) == 0) ? 16'($urandom_range(1))
                                                  : 16'($urandom_range(65535));
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_snapshot(input pid_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    drive_req  <= r;
    do @(negedge clk_i); while (!req_taken);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    out_ready_i   = 1'b0;
    drive_req     = '0;
    send_idle_pct = 25;
    recv_idle_pct = 70;
    items_sent    = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // nothing pending, then every source alone
    send_snapshot(make_snapshot(5'h00, 5'h00, 1'b0, 8'h00, 8'h00, 8'h01, 16'h0000, 16'h0000));
    for (int i = 0; i < NumSources; i++)
      send_snapshot(make_snapshot(5'(1 << i), 5'(1 << i), 1'b1, 8'h00, 8'h00, 8'h01,
                                  16'h1234 + 16'(i), 16'hC000));
    // all pending: source 0 wins, stack wraps from zero and one; then source 3 wins
    send_snapshot(make_snapshot(5'h1F, 5'h1F, 1'b1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'h0000));
    send_snapshot(make_snapshot(5'h1F, 5'h1F, 1'b1, 8'h00, 8'h00, 8'h00, 16'h8001, 16'h0001));
    send_snapshot(make_snapshot(5'h18, 5'h1F, 1'b1, 8'h00, 8'h10, 8'h20, 16'hABCD, 16'hFFFF));
    // pending but master off; enabled nothing
    send_snapshot(make_snapshot(5'h1F, 5'h1F, 1'b0, 8'h00, 8'h00, 8'h01, 16'h5555, 16'h2222));
    send_snapshot(make_snapshot(5'h00, 5'h1F, 1'b1, 8'h78, 8'h07, 8'h07, 16'hAAAA, 16'h3333));
    // each status condition raising source 1
    send_snapshot(make_snapshot(5'h02, 5'h00, 1'b1, 8'h40, 8'h90, 8'h90, 16'h0100, 16'hFFFE));
    send_snapshot(make_snapshot(5'h02, 5'h00, 1'b1, 8'h22, 8'h00, 8'h01, 16'h0200, 16'hD000));
    send_snapshot(make_snapshot(5'h02, 5'h00, 1'b1, 8'h11, 8'h00, 8'h01, 16'h0300, 16'hD000));
    send_snapshot(make_snapshot(5'h02, 5'h00, 1'b1, 8'h08, 8'h00, 8'h01, 16'h0400, 16'hD000));
    // line select without a match, selects on the wrong mode, bits 2 and 7 alone
    send_snapshot(make_snapshot(5'h02, 5'h00, 1'b1, 8'h43, 8'h10, 8'h11, 16'h0500, 16'hD000));
    send_snapshot(make_snapshot(5'h02, 5'h00, 1'b1, 8'h3B, 8'h10, 8'h11, 16'h0600, 16'hD000));
    send_snapshot(make_snapshot(5'h02, 5'h00, 1'b1, 8'h84, 8'h10, 8'h10, 16'h0700, 16'hD000));
    // status request with source 1 disabled; a pending bit 1 is kept
    send_snapshot(make_snapshot(5'h1D, 5'h00, 1'b1, 8'h48, 8'h05, 8'h05, 16'h0800, 16'hD000));
    send_snapshot(make_snapshot(5'h1C, 5'h02, 1'b1, 8'h08, 8'h05, 8'h06, 16'h0900, 16'hD000));
    // status raise with master off, and under a higher source that wins
    send_snapshot(make_snapshot(5'h02, 5'h00, 1'b0, 8'h08, 8'h05, 8'h06, 16'h0A00, 16'hD000));
    send_snapshot(make_snapshot(5'h03, 5'h01, 1'b1, 8'h08, 8'h05, 8'h06, 16'h0B00, 16'hD000));
    wait_drained();

    for (int n = 0; n < PhaseItems; n++) send_snapshot(random_snapshot());

    // long output stall while requests keep coming, so the input backs up
    send_idle_pct = 0;
    -> start_hold;
    for (int n = 0; n < 16; n++) send_snapshot(random_snapshot());

    send_idle_pct = 70;
    recv_idle_pct = 25;
    for (int n = 0; n < PhaseItems; n++) send_snapshot(random_snapshot());
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < PhaseItems; n++) send_snapshot(random_snapshot());
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);

    $display("covered %0d snapshots over three stall mixes plus a %0d-cycle output hold",
             items_sent, HoldCycles);
    $display("%0d of them dispatched an interrupt, %0d mismatches", dispatch_count, fail_count);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
